@@ rtl/force_frame_encoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Force frame encoder: assertion macros
// Shared check macros. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef FORCE_FRAME_ENCODER_TOP_DEFINES_SVH
`define FORCE_FRAME_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define FFE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffe: same-cycle check failed");
// next-cycle implication
`define FFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffe: next-cycle check failed");
`else
`define FFE_ASSERT_IMPLY(lbl, ante, cons)
`define FFE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/ffe_pkg.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder package
// Frame constants, field widths and the frame type.
// ----------------------------------------------------------------------------
package ffe_pkg;

  localparam int FORCE_W    = 21;
  localparam int MAG_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int DIG_W      = 7;
  localparam int NUM_FORCES = 3;
  localparam int FRAME_LEN  = 15;
  localparam int CNT_W      = 4;

  localparam logic [MAG_W-1:0]  MAG_MAX    = 20'd999999;
  localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'h7B;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_BYTE   = 8'h11;
  localparam logic [BYTE_W-1:0] EOF_BYTE   = 8'h7D;

  // frame positions
  localparam int POS_DIG0 = 3;
  localparam int POS_TAG  = 12;
  localparam int POS_CK   = 13;
  localparam logic [CNT_W-1:0] POS_LAST = 4'd14;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

endpackage

@@ rtl/ffe_in_if.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder input channel
// valid/ready word carrying three forces and the sort tag.
// ----------------------------------------------------------------------------
interface ffe_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ffe_pkg::FORCE_W-1:0]  force_a;
  logic signed [ffe_pkg::FORCE_W-1:0]  force_b;
  logic signed [ffe_pkg::FORCE_W-1:0]  force_c;
  logic        [ffe_pkg::BYTE_W-1:0]   sort_tag;

  modport source (output valid, output force_a, output force_b, output force_c,
                  output sort_tag, input ready);
  modport sink   (input valid, input force_a, input force_b, input force_c,
                  input sort_tag, output ready);
endinterface

@@ rtl/ffe_out_if.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder output channel
// valid/ready word carrying one frame byte and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface ffe_out_if;
  logic                              valid;
  logic                              ready;
  logic [ffe_pkg::BYTE_W-1:0]        frame_byte;
  logic                              last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

@@ rtl/force_frame_encoder_top.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder top level
// Three forces and a sort tag in, one 15-byte serial frame out per word.
// ----------------------------------------------------------------------------
// Path: the first frame byte of a word leaves the 7 encode stages and is
//   then loaded into the byte shifter, if the shifter is free.
// Throughput: the byte shifter sends one byte a cycle while out_word.ready
//   is high; up to 7 further words queue in the encode stages.
// Reset: rst_n is synchronous, active low; it clears the stage valid bits and
//   the shifter's busy flag and byte count. Data registers are not reset.
// ----------------------------------------------------------------------------
`include "force_frame_encoder_top_defines.svh"

module force_frame_encoder_top (
  input  logic      clk,
  input  logic      rst_n,
  ffe_in_if.sink    in_word,
  ffe_out_if.source out_word
);

  // encode pipeline -> byte shifter
  logic            frm_valid;
  logic            frm_ready;
  ffe_pkg::frame_t frm_data;

  ffe_encode_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .force_a   (in_word.force_a),
    .force_b   (in_word.force_b),
    .force_c   (in_word.force_c),
    .sort_tag  (in_word.sort_tag),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data)
  );

  // Byte shifter. Byte 0 of sh_r is always the byte on the output; each
  // taken byte shifts the frame down by one. A new frame loads in the same
  // cycle the tail byte leaves, so frames go out with no gap.
  logic                      busy_r;
  logic                      busy_nxt;
  logic [ffe_pkg::CNT_W-1:0] cnt_r;
  logic [ffe_pkg::CNT_W-1:0] cnt_nxt;
  ffe_pkg::frame_t           sh_r;
  logic                      is_last;
  logic                      out_hs;
  logic                      last_hs;
  logic                      ld;

  assign is_last   = (cnt_r == ffe_pkg::POS_LAST);
  assign out_hs    = busy_r && out_word.ready;
  assign last_hs   = out_hs && is_last;
  assign frm_ready = !busy_r || last_hs;
  assign ld        = frm_valid && frm_ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (ld) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (last_hs) begin
      busy_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (out_hs) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // frame data: load whole frame, or shift one byte down per taken byte
  always_ff @(posedge clk) begin
    if (ld) begin
      sh_r <= frm_data;
    end else if (out_hs) begin
      sh_r <= ffe_pkg::frame_t'(sh_r >> ffe_pkg::BYTE_W);
    end
  end

  assign out_word.valid      = busy_r;
  assign out_word.frame_byte = sh_r[0];
  assign out_word.last_byte  = is_last;

  // checks
  `FFE_ASSERT_IMPLY(a_sof_first, busy_r && cnt_r == '0, sh_r[0] == ffe_pkg::SOF_BYTE)
  `FFE_ASSERT_IMPLY(a_eof_last, out_word.valid && out_word.last_byte, out_word.frame_byte == ffe_pkg::EOF_BYTE)
  `FFE_ASSERT_NEXT(a_count_steps, out_hs && !is_last, busy_r && cnt_r == $past(cnt_r) + 1'b1)
  `FFE_ASSERT_IMPLY(a_count_range, busy_r, cnt_r <= ffe_pkg::POS_LAST)

endmodule

@@ rtl/ffe_encode_pipe.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder: encode pipeline
// Seven-stage pipeline from forces to a complete 15-byte frame.
// ----------------------------------------------------------------------------
`include "force_frame_encoder_top_defines.svh"

module ffe_encode_pipe (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ffe_pkg::FORCE_W-1:0] force_a,
  input  logic signed [ffe_pkg::FORCE_W-1:0] force_b,
  input  logic signed [ffe_pkg::FORCE_W-1:0] force_c,
  input  logic        [ffe_pkg::BYTE_W-1:0]  sort_tag,
  output logic                               frm_valid,
  input  logic                               frm_ready,
  output ffe_pkg::frame_t                    frm_data
);

  localparam int NSTG  = 7;
  localparam int NF    = ffe_pkg::NUM_FORCES;
  localparam int FW    = ffe_pkg::FORCE_W;
  localparam int MW    = ffe_pkg::MAG_W;
  localparam int DW    = ffe_pkg::DIG_W;
  localparam int BW    = ffe_pkg::BYTE_W;
  localparam int QW    = 14;
  localparam int SUM_W = 11;
  localparam int QS_W  = 4;

  // reciprocal constants for exact divide by 100 over each value range
  localparam logic [20:0]      RCP_MAG = 21'd1342178;  // 2^27 / 100, rounded up
  localparam logic [QW-1:0]    RCP_Q   = 14'd10486;    // 2^20 / 100, rounded up
  localparam logic [SUM_W-1:0] RCP_SUM = 11'd1311;     // 2^17 / 100, rounded up

  typedef logic [2:0][BW-1:0] grp_t;  // hi, mid, lo

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vld_in;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || frm_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign vld_in    = {vld_r[NSTG-2:0], in_valid};
  assign in_ready  = adv[0];
  assign frm_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  // stage 1: sign and saturated magnitude
  logic signed [FW-1:0] f_in  [NF];
  logic        [FW-1:0] s1_abs[NF];
  logic        [NF-1:0] s1_neg_r;
  logic        [MW-1:0] s1_mag_r[NF];
  logic        [BW-1:0] s1_tag_r;

  assign f_in[0] = force_a;
  assign f_in[1] = force_b;
  assign f_in[2] = force_c;

  always_comb begin
    for (int l = 0; l < NF; l++) begin
      s1_abs[l] = f_in[l][FW-1] ? (FW'(0) - unsigned'(f_in[l])) : unsigned'(f_in[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < NF; l++) begin
        s1_neg_r[l] <= f_in[l][FW-1];
        s1_mag_r[l] <= (s1_abs[l] > FW'(ffe_pkg::MAG_MAX)) ? ffe_pkg::MAG_MAX
                                                           : s1_abs[l][MW-1:0];
      end
      s1_tag_r <= sort_tag;
    end
  end

  // stage 2: q = mag / 100
  logic [40:0]   s2_prod[NF];
  logic [NF-1:0] s2_neg_r;
  logic [MW-1:0] s2_mag_r[NF];
  logic [QW-1:0] s2_q_r[NF];
  logic [BW-1:0] s2_tag_r;

  always_comb begin
    for (int l = 0; l < NF; l++) begin
      s2_prod[l] = 41'(s1_mag_r[l]) * 41'(RCP_MAG);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int l = 0; l < NF; l++) begin
        s2_mag_r[l] <= s1_mag_r[l];
        s2_q_r[l]   <= s2_prod[l][40:27];
      end
      s2_neg_r <= s1_neg_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // stage 3: lo = mag - 100q, hi = q / 100
  logic [27:0]   s3_prod[NF];
  logic [MW-1:0] s3_qx100[NF];
  logic [NF-1:0] s3_neg_r;
  logic [QW-1:0] s3_q_r[NF];
  logic [DW-1:0] s3_hi_r[NF];
  logic [DW-1:0] s3_lo_r[NF];
  logic [BW-1:0] s3_tag_r;

  always_comb begin
    for (int l = 0; l < NF; l++) begin
      s3_prod[l]  = 28'(s2_q_r[l]) * 28'(RCP_Q);
      s3_qx100[l] = MW'(s2_q_r[l]) * MW'(100);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int l = 0; l < NF; l++) begin
        s3_q_r[l]  <= s2_q_r[l];
        s3_hi_r[l] <= s3_prod[l][26:20];
        s3_lo_r[l] <= DW'(s2_mag_r[l] - s3_qx100[l]);
      end
      s3_neg_r <= s2_neg_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // stage 4: mid = q - 100 hi, digit bytes
  logic [QW-1:0] s4_hix100[NF];
  grp_t          s4_dig_r[NF];
  logic [BW-1:0] s4_tag_r;

  always_comb begin
    for (int l = 0; l < NF; l++) begin
      s4_hix100[l] = QW'(s3_hi_r[l]) * QW'(100);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int l = 0; l < NF; l++) begin
        s4_dig_r[l][0] <= {s3_neg_r[l], s3_hi_r[l]};
        s4_dig_r[l][1] <= {1'b0, DW'(s3_q_r[l] - s4_hix100[l])};
        s4_dig_r[l][2] <= {1'b0, s3_lo_r[l]};
      end
      s4_tag_r <= s3_tag_r;
    end
  end

  // stage 5: byte sum over frame bytes 1..12
  logic [SUM_W-1:0] s5_sum;
  grp_t             s5_dig_r[NF];
  logic [BW-1:0]    s5_tag_r;
  logic [SUM_W-1:0] s5_sum_r;

  always_comb begin
    s5_sum = SUM_W'(ffe_pkg::ZERO_BYTE) + SUM_W'(ffe_pkg::CMD_BYTE) + SUM_W'(s4_tag_r);
    for (int l = 0; l < NF; l++) begin
      s5_sum = s5_sum + SUM_W'(s4_dig_r[l][0]) + SUM_W'(s4_dig_r[l][1])
             + SUM_W'(s4_dig_r[l][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_dig_r <= s4_dig_r;
      s5_tag_r <= s4_tag_r;
      s5_sum_r <= s5_sum;
    end
  end

  // stage 6: sum / 100
  logic [21:0]      s6_prod;
  grp_t             s6_dig_r[NF];
  logic [BW-1:0]    s6_tag_r;
  logic [SUM_W-1:0] s6_sum_r;
  logic [QS_W-1:0]  s6_qs_r;

  assign s6_prod = 22'(s5_sum_r) * 22'(RCP_SUM);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_dig_r <= s5_dig_r;
      s6_tag_r <= s5_tag_r;
      s6_sum_r <= s5_sum_r;
      s6_qs_r  <= s6_prod[20:17];
    end
  end

  // stage 7: checksum = sum mod 100
  logic [SUM_W-1:0] s7_qsx100;
  grp_t             s7_dig_r[NF];
  logic [BW-1:0]    s7_tag_r;
  logic [DW-1:0]    s7_ck_r;

  assign s7_qsx100 = SUM_W'(s6_qs_r) * SUM_W'(100);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_dig_r <= s6_dig_r;
      s7_tag_r <= s6_tag_r;
      s7_ck_r  <= DW'(s6_sum_r - s7_qsx100);
    end
  end

  // frame assembly
  always_comb begin
    frm_data    = '0;
    frm_data[0] = ffe_pkg::SOF_BYTE;
    frm_data[1] = ffe_pkg::ZERO_BYTE;
    frm_data[2] = ffe_pkg::CMD_BYTE;
    for (int l = 0; l < NF; l++) begin
      for (int j = 0; j < 3; j++) begin
        frm_data[ffe_pkg::POS_DIG0 + 3 * l + j] = s7_dig_r[l][j];
      end
    end
    frm_data[ffe_pkg::POS_TAG]       = s7_tag_r;
    frm_data[ffe_pkg::POS_CK]        = {1'b0, s7_ck_r};
    frm_data[ffe_pkg::FRAME_LEN - 1] = ffe_pkg::EOF_BYTE;
  end

  // checks
  `FFE_ASSERT_IMPLY(a_stall_only_when_full, !in_ready, &vld_r)
  `FFE_ASSERT_IMPLY(a_ck_range, frm_valid, s7_ck_r < 7'd100)
  for (genvar g = 0; g < NF; g++) begin : g_chk
    `FFE_ASSERT_IMPLY(a_digit_range, vld_r[3], s4_dig_r[g][0][DW-1:0] < 7'd100 && s4_dig_r[g][1] < 8'd100 && s4_dig_r[g][2] < 8'd100)
  end

endmodule

@@ sim/force_frame_encoder_checker.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder checker
// Watches both channels, predicts the 15-byte frame of every accepted input
// word and compares each accepted output word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module force_frame_encoder_checker
  import ffe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ffe_in_if           in_mon,
  ffe_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned bytes_pending
);

  typedef struct packed {
    byte_t frame_byte;
    logic  last_byte;
  } frame_beat_t;

  frame_beat_t pending_bytes[$];

  // {high, mid, low} base-100 digits of one force, sign in bit 7 of high
  function automatic logic [3*BYTE_W-1:0] force_digits(logic [FORCE_W-1:0] raw);
    logic [FORCE_W-1:0] mag_bits;
    int unsigned        mag;
    byte_t              hi;
    byte_t              mid;
    byte_t              lo;
    mag_bits = raw[FORCE_W-1] ? (~raw + 1'b1) : raw;
    mag      = mag_bits;
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
    end
    hi  = byte_t'((mag / 10000) % 100);
    mid = byte_t'((mag / 100) % 100);
    lo  = byte_t'(mag % 100);
    if (raw[FORCE_W-1]) begin
      hi[BYTE_W-1] = 1'b1;
    end
    return {hi, mid, lo};
  endfunction

  function automatic frame_t encode_frame(logic [FORCE_W-1:0] fa, logic [FORCE_W-1:0] fb,
                                          logic [FORCE_W-1:0] fc, byte_t tag);
    frame_t      f;
    int unsigned sum;
    f[0] = SOF_BYTE;
    f[1] = ZERO_BYTE;
    f[2] = CMD_BYTE;
    {f[POS_DIG0],   f[POS_DIG0+1], f[POS_DIG0+2]} = force_digits(fa);
    {f[POS_DIG0+3], f[POS_DIG0+4], f[POS_DIG0+5]} = force_digits(fb);
    {f[POS_DIG0+6], f[POS_DIG0+7], f[POS_DIG0+8]} = force_digits(fc);
    f[POS_TAG] = tag;
    sum = 0;
    for (int k = 1; k <= POS_TAG; k++) begin
      sum += f[k];
    end
    f[POS_CK]        = byte_t'(sum % 100);
    f[FRAME_LEN-1]   = EOF_BYTE;
    return f;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    frame_t      f;
    frame_beat_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        f = encode_frame(in_mon.force_a, in_mon.force_b, in_mon.force_c, in_mon.sort_tag);
        for (int k = 0; k < FRAME_LEN; k++) begin
          pending_bytes.push_back('{frame_byte: f[k], last_byte: (k == FRAME_LEN - 1)});
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                    out_mon.frame_byte, out_mon.last_byte));
        end else begin
          want = pending_bytes.pop_front();
          if (out_mon.frame_byte !== want.frame_byte) begin
            report_mismatch($sformatf("frame_byte got %02h want %02h",
                                      out_mon.frame_byte, want.frame_byte));
          end
          if (out_mon.last_byte !== want.last_byte) begin
            report_mismatch($sformatf("last_byte got %0b want %0b (byte %02h)",
                                      out_mon.last_byte, want.last_byte, want.frame_byte));
          end
        end
      end
    end
    bytes_pending <= pending_bytes.size();
  end

endmodule

@@ sim/force_frame_encoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// Force frame encoder testbench
// Drives directed and random force words with random idling on both sides,
// a long output hold-off and drain pauses; the checker scores every byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module force_frame_encoder_top_tb;
  import ffe_pkg::*;

  localparam int RANDOM_WORDS = 446;
  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 400;  // well past what 8 queued words need to fill up
  localparam int DRAIN_CYCLES = 40;   // first byte shows after the encode stages and the byte shifter

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned bytes_pending;

  // stretch controls, written by the sender, read by the receiver
  bit calm;     // no idling on either side while set
  bit hold_go;  // ask the receiver for its long hold-off

  ffe_in_if  in_ch ();
  ffe_out_if out_ch ();

  force_frame_encoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  force_frame_encoder_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Random force values. Mostly in-range, with small values, digit-boundary
  // values, saturation cases and raw 21-bit patterns mixed in.
  // ---------------------------------------------------------------------------
  function automatic logic [FORCE_W-1:0] pick_force();
    int r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) begin
      r = int'($urandom_range(1999998)) - 999999;
    end else if (sel < 65) begin
      r = int'($urandom_range(200)) - 100;
    end else if (sel < 80) begin
      r = int'($urandom());  // every bit of the field, saturation included
    end else if (sel < 90) begin
      case ($urandom_range(11))
        0:       r = 999999;
        1:       r = -999999;
        2:       r = 1000000;
        3:       r = -1000000;
        4:       r = 0;
        5:       r = -1;
        6:       r = 1048575;   // largest positive code
        7:       r = -1048576;  // most negative code
        8:       r = 99;
        9:       r = -100;
        10:      r = 9999;
        default: r = 10000;
      endcase
    end else begin
      // whole hundreds / ten-thousands, so low digits sit at zero
      r = int'($urandom_range(99)) * 10000 + int'($urandom_range(99)) * 100;
      if ($urandom_range(1)) begin
        r = -r;
      end
    end
    return r[FORCE_W-1:0];
  endfunction

  // Offer one word and hold it until accepted. Idle cycles come first, so
  // valid never gets two assignments in one step.
  task automatic send_word(int fa, int fb, int fc, int tag);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.force_a  <= fa[FORCE_W-1:0];
    in_ch.force_b  <= fb[FORCE_W-1:0];
    in_ch.force_c  <= fc[FORCE_W-1:0];
    in_ch.sort_tag <= tag[BYTE_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering until every predicted byte has come out.
  task automatic wait_frames_out();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, one long hold-off on request, none while calm.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    calm           <= 1'b0;
    hold_go        <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.force_a  <= '0;
    in_ch.force_b  <= '0;
    in_ch.force_c  <= '0;
    in_ch.sort_tag <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range ends, sign cases, saturation, digit boundaries
    send_word(0, 0, 0, 0);
    send_word(999999, 999999, 999999, 255);
    send_word(-999999, -999999, -999999, 0);
    send_word(-1, 1, 0, 128);
    send_word(1048575, -1048576, -1000000, 1);
    send_word(1000000, -1048575, 524287, 127);
    send_word(-524288, 524288, -524287, 170);
    send_word(10000, 9999, 100, 85);
    send_word(-99, -100, -10000, 200);
    send_word(123456, -654321, 987654, 254);
    send_word(990000, -990099, 9900, 16);
    send_word(0, -1048576, 1048575, 238);
    send_word(-999998, 1, -2, 119);
    send_word(500000, -500000, 999900, 1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // sender pause until the block is empty, twice
      if ((i == 60) || (i == 380)) begin
        wait_frames_out();
      end
      // long receiver hold-off; the sender keeps offering and gets stalled
      if (i == 150) begin
        hold_go <= 1'b1;
      end
      // stretch with no idling on either side
      if (i == 250) begin
        calm <= 1'b1;
      end
      if (i == 330) begin
        calm <= 1'b0;
      end
      send_word(int'(pick_force()), int'(pick_force()), int'(pick_force()),
                int'($urandom_range(255)));
    end

    // drain and let the block settle before the verdict
    wait_frames_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
